### hw/rtl/knvs_pkg.sv
// knvs_pkg: types, constants and helpers shared by the k-nearest column search
// used by knvs_isqrt, knvs_dist, knvs_cell and k_nearest_vector_select
// no dependencies
package knvs_pkg;

    // sizes
    localparam int MAX_DIM      = 256;
    localparam int MAX_K        = 16;
    localparam int ELEMENT_BITS = 16;
    localparam int POS_W        = $clog2(MAX_DIM);
    localparam int LEN_W        = $clog2(MAX_DIM + 1);
    localparam int K_W          = $clog2(MAX_K + 1);
    localparam int RANK_W       = 4;
    localparam int IDX_W        = 16;
    localparam int CNT_W        = IDX_W + 1;
    localparam int DIST_W       = 40;
    localparam int KEEP_W       = DIST_W + 1;
    localparam int TERM_W       = 2 * ELEMENT_BITS;
    localparam int ROOT_W       = DIST_W / 2;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;
    localparam logic [KEEP_W-1:0] DIST_INF = '1;

    // metric codes
    localparam logic [1:0] METRIC_SQ = 2'd0;
    localparam logic [1:0] METRIC_L2 = 2'd1;
    localparam logic [1:0] METRIC_L1 = 2'd2;

    // register indexes
    localparam logic [1:0] REG_METRIC = 2'd0;
    localparam logic [1:0] REG_VLEN   = 2'd1;
    localparam logic [1:0] REG_NUMK   = 2'd2;

    // one kept slot
    typedef struct packed {
        logic [KEEP_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
        logic              filled;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '{distance: DIST_INF, idx: '0, filled: 1'b0};

    // commands from the sequencer to every cell
    typedef struct packed {
        logic insert;
        logic advance;
        logic clear;
    } cell_ctrl_t;

    // finished column distance from the accumulator
    typedef struct packed {
        logic              valid;
        logic              final_col;
        logic [DIST_W-1:0] distance;
    } cand_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_ROOT,
        ST_SEND
    } state_t;

    // register values outside their range are clamped when used
    function automatic logic [LEN_W-1:0] clamp_len(input logic [8:0] v);
        logic [LEN_W-1:0] r;
        if (v == 9'd0) begin
            r = LEN_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = LEN_W'(MAX_DIM);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

    function automatic logic [K_W-1:0] clamp_k(input logic [4:0] v);
        logic [K_W-1:0] r;
        if (v == 5'd0) begin
            r = K_W'(1);
        end else if (32'(v) > MAX_K) begin
            r = K_W'(MAX_K);
        end else begin
            r = K_W'(v);
        end
        return r;
    endfunction

endpackage

### hw/rtl/knvs_isqrt.sv
// knvs_isqrt: floor square root of a 40-bit value, one result bit per cycle
// depends on knvs_pkg
module knvs_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [knvs_pkg::DIST_W-1:0]   operand,
    output logic                          busy,
    output logic                          done,
    output logic [knvs_pkg::ROOT_W-1:0]   root
);
    import knvs_pkg::*;

    localparam int REM_W  = ROOT_W + 2;
    localparam int WIDE_W = REM_W + 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DIST_W-1:0] op_reg, op_next;
    logic              done_reg, done_next;
    logic [WIDE_W-1:0] rem_wide;
    logic [WIDE_W-1:0] trial;

    // one digit pair per cycle: bring down two bits, try subtracting 4r+1
    always_comb begin
        rem_wide  = {rem_reg, op_reg[DIST_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        step_next = step_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (start) begin
            step_next = STEP_W'(ROOT_W);
            rem_next  = '0;
            root_next = '0;
            op_next   = operand;
        end else if (step_reg != '0) begin
            op_next   = {op_reg[DIST_W-3:0], 2'b00};
            step_next = step_reg - STEP_W'(1);
            if (rem_wide >= trial) begin
                rem_next  = REM_W'(rem_wide - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_wide);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        op_reg   <= op_next;
    end

    assign busy = (step_reg != '0);
    assign done = done_reg;
    assign root = root_reg;

endmodule

### hw/rtl/knvs_dist.sv
// knvs_dist: query store and per-column distance accumulation, three stages
// (store read, difference and square or magnitude, saturating add); depends on knvs_pkg
module knvs_dist (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                beat,
    input  logic                                mode,
    input  logic signed [knvs_pkg::ELEMENT_BITS-1:0] value,
    input  logic                                final_col,
    input  logic [1:0]                          metric,
    input  logic [knvs_pkg::LEN_W-1:0]          len_eff,
    input  logic                                run_clear,
    output logic                                ends_column,
    output knvs_pkg::cand_t                     cand
);
    import knvs_pkg::*;

    localparam int DIFF_W = ELEMENT_BITS + 1;

    logic signed [ELEMENT_BITS-1:0] qstore [MAX_DIM];

    logic [POS_W-1:0]               qpos_reg, epos_reg;
    logic signed [ELEMENT_BITS-1:0] qrd_reg;
    logic                           s1_valid_reg, s1_end_reg, s1_final_reg;
    logic signed [ELEMENT_BITS-1:0] s1_value_reg;
    logic                           s2_valid_reg, s2_end_reg, s2_final_reg;
    logic [TERM_W-1:0]              s2_term_reg, s2_term_next;
    logic [DIST_W-1:0]              acc_reg;
    logic                           q_wrap;
    logic signed [DIFF_W-1:0]       diff;
    logic [ELEMENT_BITS-1:0]        mag;
    logic [KEEP_W-1:0]              sum;
    logic [DIST_W-1:0]              sum_sat;

    // position bookkeeping
    assign q_wrap      = (({1'b0, qpos_reg} + LEN_W'(1)) >= len_eff);
    assign ends_column = (({1'b0, epos_reg} + LEN_W'(1)) >= len_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qpos_reg <= '0;
            epos_reg <= '0;
        end else if (beat && !mode) begin
            qpos_reg <= q_wrap ? '0 : qpos_reg + POS_W'(1);
        end else if (beat && mode) begin
            epos_reg <= ends_column ? '0 : epos_reg + POS_W'(1);
        end else if (run_clear) begin
            qpos_reg <= '0;
            epos_reg <= '0;
        end
    end

    // query store: write on query beats, registered read on matrix beats
    always_ff @(posedge aclk) begin
        if (beat && !mode) begin
            qstore[qpos_reg] <= value;
        end
        if (beat && mode) begin
            qrd_reg <= qstore[epos_reg];
        end
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= beat && mode;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // difference magnitude and per-element term
    always_comb begin
        diff = DIFF_W'(s1_value_reg) - DIFF_W'(qrd_reg);
        mag  = diff[DIFF_W-1] ? ELEMENT_BITS'(-diff) : ELEMENT_BITS'(diff);
        if (metric == METRIC_L1) begin
            s2_term_next = TERM_W'(mag);
        end else begin
            s2_term_next = TERM_W'(mag) * TERM_W'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && mode) begin
            s1_value_reg <= value;
            s1_end_reg   <= ends_column;
            s1_final_reg <= final_col;
        end
        s2_term_reg  <= s2_term_next;
        s2_end_reg   <= s1_end_reg;
        s2_final_reg <= s1_final_reg;
    end

    // saturating accumulation, restarted after each column
    assign sum     = KEEP_W'(acc_reg) + KEEP_W'(s2_term_reg);
    assign sum_sat = sum[KEEP_W-1] ? DIST_SAT : sum[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_reg <= s2_end_reg ? '0 : sum_sat;
        end
    end

    assign cand.valid     = s2_valid_reg && s2_end_reg;
    assign cand.final_col = s2_final_reg;
    assign cand.distance  = sum_sat;

endmodule

### hw/rtl/knvs_cell.sv
// knvs_cell: one slot of the sorted nearest-column chain
// depends on knvs_pkg; takes a candidate or its lower neighbor on insert
module knvs_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  knvs_pkg::cell_ctrl_t  ctrl,
    input  logic                  active,
    input  knvs_pkg::entry_t      cand,
    input  logic                  prev_gt,
    input  knvs_pkg::entry_t      prev_entry,
    input  knvs_pkg::entry_t      next_entry,
    output knvs_pkg::entry_t      entry,
    output logic                  gt
);
    import knvs_pkg::*;

    entry_t entry_reg, entry_next;

    // candidate strictly better than this slot: ties stay ahead
    assign gt = (entry_reg.distance > cand.distance);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clear) begin
            entry_next = ENTRY_EMPTY;
        end else if (ctrl.advance) begin
            entry_next = next_entry;
        end else if (ctrl.insert && active && gt) begin
            entry_next = prev_gt ? prev_entry : cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= ENTRY_EMPTY;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### hw/rtl/k_nearest_vector_select.sv
// k_nearest_vector_select: streaming k-nearest column search, top level
// depends on knvs_pkg, knvs_dist, knvs_cell, knvs_isqrt
//
//   channel | dir | beat carries
//   s_      | in  | tdata: value[15:0]; tuser: mode; tlast: final_column
//   m_      | out | tdata: rank, column_index, distance, pad; tuser: filled,
//           |     | index_overflow; tlast: last
//   cfg_    | in  | cfg_index: register, cfg_data: value (always ready)
//
// elements are taken one per cycle while the input is not stalled; a column's distance
// enters the cell chain after its last beat (store read, square, then accumulate and insert)
// after the final column's last beat the input stalls; the first result is offered once the
// head slot is loaded, the next ones after each chain advance and reload, and in euclidean
// mode each filled slot also waits for the bit-serial root unit
// reset (aresetn low, synchronous) empties the chain and all counters;
// the query store keeps its contents only once written
module k_nearest_vector_select (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [3:0] rank, [19:4] column_index, [59:20] distance
    output logic [1:0]  m_tuser,   // [0] filled, [1] index_overflow
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import knvs_pkg::*;

    state_t               state_reg, state_next;
    logic [1:0]           metric_reg;
    logic [8:0]           vlen_reg;
    logic [4:0]           numk_reg;
    logic [LEN_W-1:0]     len_eff;
    logic [K_W-1:0]       k_eff;
    logic                 hold_reg;
    logic [CNT_W-1:0]     col_cnt_reg;
    logic                 ovf_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic                 out_filled_reg;
    logic                 s_beat;
    logic                 ends_column;
    logic                 run_clear;
    logic                 rank_last;
    logic                 load_out;
    logic                 root_start, root_busy, root_done;
    logic [ROOT_W-1:0]    root_val;
    cand_t                cand;
    entry_t               cand_entry;
    entry_t               head;
    cell_ctrl_t           ctrl;
    entry_t               cell_entry [MAX_K];
    logic                 cell_gt [MAX_K];

    assign len_eff   = clamp_len(vlen_reg);
    assign k_eff     = clamp_k(numk_reg);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg <= METRIC_SQ;
            vlen_reg   <= 9'd1;
            numk_reg   <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_METRIC: metric_reg <= cfg_data[1:0];
                REG_VLEN:   vlen_reg   <= cfg_data;
                REG_NUMK:   numk_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // input stalls from the final column's last beat until the run is emitted
    assign s_tready = !hold_reg;
    assign s_beat   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else if (s_beat && s_tuser[0] && ends_column && s_tlast) begin
            hold_reg <= 1'b1;
        end else if (run_clear) begin
            hold_reg <= 1'b0;
        end
    end

    knvs_dist u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat        (s_beat),
        .mode        (s_tuser[0]),
        .value       (s_tdata),
        .final_col   (s_tlast),
        .metric      (metric_reg),
        .len_eff     (len_eff),
        .run_clear   (run_clear),
        .ends_column (ends_column),
        .cand        (cand)
    );

    // column numbering, saturating; late columns only flag overflow
    always_ff @(posedge aclk) begin
        if (!aresetn || run_clear) begin
            col_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end else if (cand.valid) begin
            if (col_cnt_reg[CNT_W-1]) begin
                ovf_reg <= 1'b1;
            end else begin
                col_cnt_reg <= col_cnt_reg + CNT_W'(1);
            end
        end
    end

    assign cand_entry = '{distance: KEEP_W'(cand.distance), idx: col_cnt_reg[IDX_W-1:0],
                          filled: 1'b1};

    // sorted slot chain, nearest at cell 0
    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_cell
            entry_t prev_e, next_e;
            logic   prev_g;
            if (gi == 0) begin : g_head
                assign prev_e = ENTRY_EMPTY;
                assign prev_g = 1'b0;
            end else begin : g_body
                assign prev_e = cell_entry[gi-1];
                assign prev_g = cell_gt[gi-1];
            end
            if (gi == MAX_K - 1) begin : g_tail
                assign next_e = ENTRY_EMPTY;
            end else begin : g_mid
                assign next_e = cell_entry[gi+1];
            end
            knvs_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .active     (K_W'(gi) < k_eff),
                .cand       (cand_entry),
                .prev_gt    (prev_g),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (cell_entry[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    assign head = cell_entry[0];

    knvs_isqrt u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (head.distance[DIST_W-1:0]),
        .busy    (root_busy),
        .done    (root_done),
        .root    (root_val)
    );

    assign rank_last = (K_W'(rank_reg) + K_W'(1) == k_eff);

    // emission sequencer
    always_comb begin
        state_next   = state_reg;
        root_start   = 1'b0;
        load_out     = 1'b0;
        run_clear    = 1'b0;
        ctrl.insert  = 1'b0;
        ctrl.advance = 1'b0;
        ctrl.clear   = 1'b0;
        case (state_reg)
            ST_RUN: begin
                ctrl.insert = cand.valid && !col_cnt_reg[CNT_W-1];
                if (cand.valid && cand.final_col) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (head.filled && metric_reg == METRIC_L2) begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end else begin
                    load_out   = 1'b1;
                    state_next = ST_SEND;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (rank_last) begin
                        ctrl.clear = 1'b1;
                        run_clear  = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        ctrl.advance = 1'b1;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // rank counter
    always_ff @(posedge aclk) begin
        if (!aresetn || run_clear) begin
            rank_reg <= '0;
        end else if (ctrl.advance) begin
            rank_reg <= rank_reg + RANK_W'(1);
        end
    end

    // output holding register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_idx_reg    <= head.filled ? head.idx : '0;
            out_dist_reg   <= head.filled ? head.distance[DIST_W-1:0] : DIST_SAT;
            out_filled_reg <= head.filled;
        end else if (root_start) begin
            out_idx_reg    <= head.idx;
            out_filled_reg <= 1'b1;
        end else if (root_done) begin
            out_dist_reg <= DIST_W'(root_val);
        end
    end

    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = {4'b0000, out_dist_reg, out_idx_reg, rank_reg};
    assign m_tuser  = {ovf_reg, out_filled_reg};
    assign m_tlast  = rank_last;

    // checks
    a_no_input_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !s_tready)
        else $error("input accepted during emission");

    a_chain_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_entry[0].distance <= cell_entry[1].distance)
        else $error("slot chain out of order");

    a_root_only_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        root_busy |-> (state_reg == ST_ROOT))
        else $error("root unit busy outside its wait state");

    a_run_ends_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (col_cnt_reg == '0 && !cell_entry[0].filled))
        else $error("run state not cleared after last result");

endmodule
